### design/sida_pkg.sv
// Shared types and character codes for the signed integer to decimal ASCII converter.
package sida_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [3:0] BCD_FIVE    = 4'd5;
	localparam logic [3:0] BCD_THREE   = 4'd3;
	localparam logic [3:0] BCD_NINE    = 4'd9;

endpackage

### design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter: bit-serial binary to BCD and character emitter.
//
// Each input transfer carries one two's complement integer of VALUE_WIDTH bits. The block
// sends its decimal text one ASCII character per output transfer, most significant first:
// a leading '-' for negative values, no leading zeros, a single '0' for zero, and tlast on
// the final character. The most negative value converts in full (at 32 bits
// "-2147483648"). The magnitude is shifted one bit per cycle through a row of add-3 BCD
// digit lanes until all VALUE_WIDTH bits are in; leading zero digits are then dropped
// one per cycle (up to NDIG-1 of them, NDIG = 10 at 32 bits), the sign or the first
// digit is picked next, and the '-' and each digit are loaded into the output register
// whenever it is free. Dropped and emitted digits always add up to NDIG. One item is
// in work at a time; the next one is accepted while the final character still waits
// in the output register.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] value
	// Output stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [7:0]                            m_axis_tdata,  // [7:0] character
	output logic                                  m_axis_tlast
);

	// Decimal digits needed for 2^(VALUE_WIDTH-1) and counter widths
	localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BW   = 4 * NDIG;
	localparam int BCW  = $clog2(VALUE_WIDTH);
	localparam int DCW  = $clog2(NDIG + 1);

	sida_pkg::state_t state_q, state_d;

	logic                   neg_q, neg_d;
	logic [VALUE_WIDTH-1:0] mag_q, mag_d;
	logic [BW-1:0]          bcd_q, bcd_d;
	logic [BW-1:0]          bcd_adj;
	logic [BCW-1:0]         bitcnt_q, bitcnt_d;
	logic [DCW-1:0]         digcnt_q, digcnt_d;
	logic                   out_valid_q, out_valid_d;
	logic [7:0]             out_char_q, out_char_d;
	logic                   out_last_q, out_last_d;
	logic                   out_free;
	logic [3:0]             top_digit;
	logic [VALUE_WIDTH-1:0] value_in;

	assign value_in  = s_axis_tdata[VALUE_WIDTH-1:0];
	assign out_free  = !out_valid_q || m_axis_tready;
	assign top_digit = bcd_q[BW-1 -: 4];

	// Add three to every digit of five or more before the next shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= sida_pkg::BCD_FIVE) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + sida_pkg::BCD_THREE;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Sequence conversion, zero skipping and character emission
	always_comb begin
		state_d     = state_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		bcd_d       = bcd_q;
		bitcnt_d    = bitcnt_q;
		digcnt_d    = digcnt_q;
		out_char_d  = out_char_q;
		out_last_d  = out_last_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		case (state_q)
			sida_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					neg_d    = value_in[VALUE_WIDTH-1];
					mag_d    = value_in[VALUE_WIDTH-1] ? (~value_in + 1'b1) : value_in;
					bcd_d    = '0;
					bitcnt_d = BCW'(VALUE_WIDTH - 1);
					state_d  = sida_pkg::ST_CONV;
				end
			end
			sida_pkg::ST_CONV: begin
				bcd_d    = {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
				mag_d    = {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bitcnt_d = bitcnt_q - 1'b1;
				if (bitcnt_q == '0) begin
					digcnt_d = DCW'(NDIG);
					state_d  = sida_pkg::ST_SKIP;
				end
			end
			sida_pkg::ST_SKIP: begin
				if (top_digit == 4'd0 && digcnt_q > DCW'(1)) begin
					bcd_d    = {bcd_q[BW-5:0], 4'd0};
					digcnt_d = digcnt_q - 1'b1;
				end else if (neg_q) begin
					state_d = sida_pkg::ST_SIGN;
				end else begin
					state_d = sida_pkg::ST_EMIT;
				end
			end
			sida_pkg::ST_SIGN: begin
				if (out_free) begin
					out_char_d  = sida_pkg::ASCII_MINUS;
					out_last_d  = 1'b0;
					out_valid_d = 1'b1;
					state_d     = sida_pkg::ST_EMIT;
				end
			end
			sida_pkg::ST_EMIT: begin
				if (out_free) begin
					out_char_d  = sida_pkg::ASCII_ZERO + {4'd0, top_digit};
					out_last_d  = (digcnt_q == DCW'(1));
					out_valid_d = 1'b1;
					bcd_d       = {bcd_q[BW-5:0], 4'd0};
					digcnt_d    = digcnt_q - 1'b1;
					if (digcnt_q == DCW'(1)) begin
						state_d = sida_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sida_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sida_pkg::ST_IDLE;
			bitcnt_q    <= '0;
			digcnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			bitcnt_q    <= bitcnt_d;
			digcnt_q    <= digcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Advance payload registers
	always_ff @(posedge clk) begin
		neg_q      <= neg_d;
		mag_q      <= mag_d;
		bcd_q      <= bcd_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	assign s_axis_tready = (state_q == sida_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	// Only valid BCD digits reach the output
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sida_pkg::ST_EMIT |-> top_digit <= sida_pkg::BCD_NINE)
		else $error("non-decimal digit in emit state");

	// Emitting always has a digit left
	a_digit_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sida_pkg::ST_EMIT |-> digcnt_q != '0)
		else $error("digit count exhausted while emitting");

	// Final digit closes the run and frees the input
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sida_pkg::ST_EMIT && out_free && digcnt_q == DCW'(1))
		|=> (state_q == sida_pkg::ST_IDLE && m_axis_tvalid && m_axis_tlast))
		else $error("run did not end on final digit");

	// A minus sign never ends a run
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata == sida_pkg::ASCII_MINUS) |-> !m_axis_tlast)
		else $error("minus sign marked as last character");

endmodule

### tb/tb.sv
// Testbench for the signed integer to decimal ASCII converter: stream driver, monitor and text predictor.
module tb;

	localparam int VALUE_WIDTH = 32;
	localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int HOLD_START  = 3000;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;  // [31:0] value
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [7:0] character
	logic              m_axis_tlast;

	logic [DATA_W-1:0] values_to_send[$];
	text_char_t        expected_text[$];
	logic              in_accepted  = 1'b0;
	int                values_taken = 0;
	int                failures     = 0;
	int                tx_gap       = 0;
	int                rx_stall     = 0;
	int                hold_cycles  = 0;
	logic              hold_off;
	logic              calm;

	signed_int_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Append the decimal text of one value to the expected characters
	task automatic predict_text(input logic [VALUE_WIDTH-1:0] value);
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digits[20];
		int                     count;
		text_char_t             ch;
		begin
			mag   = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			count = 0;
			if (mag == '0) begin
				ch.code = sida_pkg::ASCII_ZERO;
				ch.last = 1'b1;
				expected_text.push_back(ch);
			end else begin
				while (mag != '0) begin
					digits[count] = 4'(mag % 10);
					mag           = mag / 10;
					count++;
				end
				if (value[VALUE_WIDTH-1]) begin
					ch.code = sida_pkg::ASCII_MINUS;
					ch.last = 1'b0;
					expected_text.push_back(ch);
				end
				for (int k = count - 1; k >= 0; k--) begin
					ch.code = sida_pkg::ASCII_ZERO + 8'(digits[k]);
					ch.last = (k == 0);
					expected_text.push_back(ch);
				end
			end
		end
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				return 0;
			else if (roll < 85)
				return $urandom_range(1, 3);
			else if (roll < 97)
				return $urandom_range(4, 12);
			else
				return $urandom_range(20, 80);
		end
	endfunction

	// Value with a chosen number of decimal digits and a random sign
	function automatic logic [VALUE_WIDTH-1:0] value_of_digits(input int ndig);
		longint lo;
		longint hi;
		logic [VALUE_WIDTH-1:0] mag;
		begin
			lo = 1;
			for (int i = 1; i < ndig; i++)
				lo = lo * 10;
			hi = lo * 10 - 1;
			if (hi > 64'sd2147483647)
				hi = 64'sd2147483647;
			if (ndig == 1)
				lo = 0;
			mag = $urandom_range(32'(hi), 32'(lo));
			return $urandom_range(0, 1) ? ('0 - mag) : mag;
		end
	endfunction

	// Run both sides without gaps for a stretch of items
	assign calm     = (values_taken >= 25) && (values_taken < 90);
	assign hold_off = (hold_cycles >= HOLD_START) && (hold_cycles < HOLD_START + HOLD_CYCLES);

	// Count receiver cycles for the long hold-off
	always @(negedge clk) begin
		if (arst_n)
			hold_cycles <= hold_cycles + 1;
	end

	// Offer queued values, hold each until its transfer, then idle for a gap that may be zero
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_accepted)) begin
			if (tx_gap > 0) begin
				tx_gap        <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (values_to_send.size() > 0) begin
				s_axis_tdata  <= values_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				tx_gap        <= calm ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Accept characters with random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall      <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 2) == 0)
				rx_stall <= pick_gap();
		end
	end

	// Check each character transfer, then predict from each value transfer
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_text.size() == 0) begin
					$error("unexpected character %0d, last %0d", m_axis_tdata, m_axis_tlast);
					failures++;
				end else begin
					want = expected_text.pop_front();
					if (m_axis_tdata !== want.code) begin
						$error("character: expected %0d, got %0d", want.code, m_axis_tdata);
						failures++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
						failures++;
					end
				end
			end
			in_accepted <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_text(s_axis_tdata[VALUE_WIDTH-1:0]);
				values_taken <= values_taken + 1;
			end
		end
	end

	// Fill the stimulus, release reset and wait for the last character
	initial begin
		logic [VALUE_WIDTH-1:0] v;
		int                     sel;

		// Extremes, digit-count boundaries and the special values
		values_to_send.push_back(32'd0);
		values_to_send.push_back(32'd1);
		values_to_send.push_back(-32'sd1);
		values_to_send.push_back(32'd9);
		values_to_send.push_back(32'd10);
		values_to_send.push_back(-32'sd10);
		values_to_send.push_back(32'd99);
		values_to_send.push_back(32'd100);
		values_to_send.push_back(-32'sd9);
		values_to_send.push_back(32'h7FFF_FFFF);
		values_to_send.push_back(32'h8000_0000);
		values_to_send.push_back(32'h8000_0001);
		values_to_send.push_back(32'd1000000000);
		values_to_send.push_back(32'd999999999);
		values_to_send.push_back(-32'sd999999999);
		values_to_send.push_back(-32'sd1000000000);
		values_to_send.push_back(32'd1234567890);
		values_to_send.push_back(32'h0000_FFFF);
		values_to_send.push_back(32'hFFFF_0000);
		values_to_send.push_back(32'h5555_5555);
		values_to_send.push_back(32'hAAAA_AAAA);
		values_to_send.push_back(32'd1000);
		values_to_send.push_back(32'd0);

		// Random values spread over every digit count, plus raw bit patterns
		for (int i = 0; i < 350; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 5)
				v = $urandom;
			else if (sel == 5)
				v = $urandom_range(0, 1) ? 32'h8000_0000 : '0;
			else
				v = value_of_digits($urandom_range(1, 10));
			values_to_send.push_back(v);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (values_to_send.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (expected_text.size() != 0) begin
			$error("%0d characters never arrived", expected_text.size());
			failures++;
		end
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Give up after a generous time
	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

endmodule

### signed_int_to_decimal_ascii.f
design/sida_pkg.sv
design/signed_int_to_decimal_ascii.sv
tb/tb.sv
